// File: design/fbpu_pkg.sv
`default_nettype none
package fbpu_pkg;

    localparam logic CMD_PIXEL   = 1'b0;
    localparam logic CMD_PALETTE = 1'b1;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [2:0] CFG_RED_SHIFT   = 3'd0;
    localparam logic [2:0] CFG_RED_BITS    = 3'd1;
    localparam logic [2:0] CFG_GREEN_SHIFT = 3'd2;
    localparam logic [2:0] CFG_GREEN_BITS  = 3'd3;
    localparam logic [2:0] CFG_BLUE_SHIFT  = 3'd4;
    localparam logic [2:0] CFG_BLUE_BITS   = 3'd5;
    localparam logic [2:0] CFG_PIXEL_BYTES = 3'd6;
    localparam logic [2:0] CFG_OUTPUT_MODE = 3'd7;

    localparam logic [2:0] MODE_GRAY     = 3'd0;
    localparam logic [2:0] MODE_RGB      = 3'd1;
    localparam logic [2:0] MODE_RAW      = 3'd2;
    localparam logic [2:0] MODE_MONO     = 3'd3;
    localparam logic [2:0] MODE_MONO_INV = 3'd4;

    localparam logic [1:0] COUNT_ONE   = 2'd1;
    localparam logic [1:0] COUNT_THREE = 2'd3;

    localparam logic [7:0] GRAY_W_RED   = 8'd77;
    localparam logic [7:0] GRAY_W_GREEN = 8'd151;
    localparam logic [7:0] GRAY_W_BLUE  = 8'd28;

    typedef struct packed {
        logic        command;
        logic [31:0] pixel_word;
        logic [1:0]  palette_channel;
        logic [7:0]  palette_index;
        logic [15:0] palette_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [1:0] byte_count;
    } t_out_item;

    typedef struct packed {
        logic [4:0] red_shift;
        logic [3:0] red_bits;
        logic [4:0] green_shift;
        logic [3:0] green_bits;
        logic [4:0] blue_shift;
        logic [3:0] blue_bits;
        logic [2:0] pixel_bytes;
        logic [2:0] output_mode;
    } t_cfg;

endpackage
`default_nettype wire

// File: design/framebuffer_pixel_unpacker_core.sv
// Packed framebuffer pixel unpacker with per-channel 16-bit palettes.
// Input channel (i_in_valid / o_in_ready) carries either a pixel to convert
// or a palette write; output channel (o_out_valid / i_out_ready) carries one
// item per pixel, none per palette write. Configuration registers are written
// through i_cfg_valid / o_cfg_ready with a register index and data; the port
// is always ready and should be used only while the block is idle.
// An accepted pixel goes through the read stage, then the result register.
// The palette read is registered at the accept edge; output formatting and
// the gray weighting sit between the read data and the result register.
// Throughput: one item per cycle while i_out_ready stays high.
// A palette write is visible to the very next pixel.
// Reset: configuration returns to its defaults and both stages empty; the
// palette memories are not cleared and must be written before they are used.
// Receiver stall: the result register and the read stage hold; o_in_ready
// drops only when both stages are full and i_out_ready is low.
`default_nettype none
module framebuffer_pixel_unpacker_core
    import fbpu_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    t_cfg        r_cfg;
    logic        r_s1_valid;
    logic [31:0] r_s1_word;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        advance;
    logic        in_acc;
    logic        pix_acc;
    logic        pal_acc;
    logic        idx_ok;
    logic [31:0] word_masked;
    logic [AW-1:0] red_addr, green_addr, blue_addr;
    logic [15:0] red_data, green_data, blue_data;
    t_out_item   n_out;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || advance;
    assign in_acc     = i_in_valid && o_in_ready;
    assign pix_acc    = in_acc && (i_in.command == CMD_PIXEL);
    assign pal_acc    = in_acc && (i_in.command == CMD_PALETTE);
    assign idx_ok     = ({1'b0, i_in.palette_index} < 9'(PALETTE_DEPTH));
    assign o_cfg_ready = 1'b1;

    always_comb begin
        case (r_cfg.pixel_bytes)
            3'd0, 3'd1: word_masked = {24'd0, i_in.pixel_word[7:0]};
            3'd2:       word_masked = {16'd0, i_in.pixel_word[15:0]};
            3'd3:       word_masked = {8'd0, i_in.pixel_word[23:0]};
            default:    word_masked = i_in.pixel_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_shift   <= 5'd16;
            r_cfg.red_bits    <= 4'd8;
            r_cfg.green_shift <= 5'd8;
            r_cfg.green_bits  <= 4'd8;
            r_cfg.blue_shift  <= 5'd0;
            r_cfg.blue_bits   <= 4'd8;
            r_cfg.pixel_bytes <= 3'd4;
            r_cfg.output_mode <= MODE_RGB;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RED_SHIFT:   r_cfg.red_shift   <= i_cfg_data[4:0];
                CFG_RED_BITS:    r_cfg.red_bits    <= i_cfg_data[3:0];
                CFG_GREEN_SHIFT: r_cfg.green_shift <= i_cfg_data[4:0];
                CFG_GREEN_BITS:  r_cfg.green_bits  <= i_cfg_data[3:0];
                CFG_BLUE_SHIFT:  r_cfg.blue_shift  <= i_cfg_data[4:0];
                CFG_BLUE_BITS:   r_cfg.blue_bits   <= i_cfg_data[3:0];
                CFG_PIXEL_BYTES: r_cfg.pixel_bytes <= i_cfg_data[2:0];
                CFG_OUTPUT_MODE: r_cfg.output_mode <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    fbpu_field_index #(.DEPTH(PALETTE_DEPTH), .AW(AW)) u_red_idx (
        .i_word(word_masked), .i_shift(r_cfg.red_shift), .i_bits(r_cfg.red_bits),
        .o_addr(red_addr)
    );
    fbpu_field_index #(.DEPTH(PALETTE_DEPTH), .AW(AW)) u_green_idx (
        .i_word(word_masked), .i_shift(r_cfg.green_shift), .i_bits(r_cfg.green_bits),
        .o_addr(green_addr)
    );
    fbpu_field_index #(.DEPTH(PALETTE_DEPTH), .AW(AW)) u_blue_idx (
        .i_word(word_masked), .i_shift(r_cfg.blue_shift), .i_bits(r_cfg.blue_bits),
        .o_addr(blue_addr)
    );

    fbpu_palette #(.DEPTH(PALETTE_DEPTH), .AW(AW)) u_red_pal (
        .i_clk(i_clk),
        .i_we(pal_acc && idx_ok && (i_in.palette_channel == CH_RED)),
        .i_waddr(i_in.palette_index[AW-1:0]), .i_wdata(i_in.palette_value),
        .i_re(pix_acc), .i_raddr(red_addr), .o_rdata(red_data)
    );
    fbpu_palette #(.DEPTH(PALETTE_DEPTH), .AW(AW)) u_green_pal (
        .i_clk(i_clk),
        .i_we(pal_acc && idx_ok && (i_in.palette_channel == CH_GREEN)),
        .i_waddr(i_in.palette_index[AW-1:0]), .i_wdata(i_in.palette_value),
        .i_re(pix_acc), .i_raddr(green_addr), .o_rdata(green_data)
    );
    fbpu_palette #(.DEPTH(PALETTE_DEPTH), .AW(AW)) u_blue_pal (
        .i_clk(i_clk),
        .i_we(pal_acc && idx_ok && (i_in.palette_channel == CH_BLUE)),
        .i_waddr(i_in.palette_index[AW-1:0]), .i_wdata(i_in.palette_value),
        .i_re(pix_acc), .i_raddr(blue_addr), .o_rdata(blue_data)
    );

    fbpu_format u_format (
        .i_cfg(r_cfg), .i_word(r_s1_word),
        .i_red(red_data[15:8]), .i_green(green_data[15:8]), .i_blue(blue_data[15:8]),
        .o_item(n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= pix_acc;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_word <= word_masked;
        end
        if (advance && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_pal_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pal_acc |=> !r_s1_valid)
        else $error("palette write produced a pending item");

    a_pix_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc |=> r_s1_valid)
        else $error("accepted pixel lost before read stage");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1_word)))
        else $error("read stage changed while stalled");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

// File: design/fbpu_field_index.sv
`default_nettype none
module fbpu_field_index #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic [31:0]   i_word,
    input  wire logic [4:0]    i_shift,
    input  wire logic [3:0]    i_bits,
    output logic      [AW-1:0] o_addr
);

    function automatic logic [7:0] f_mod(input logic [7:0] v);
        logic [15:0] rem;
        rem = {8'd0, v};
        for (int k = 7; k >= 0; k--) begin
            if (rem >= (16'(DEPTH) << k)) begin
                rem = rem - (16'(DEPTH) << k);
            end
        end
        return rem[7:0];
    endfunction

    logic [3:0]  len;
    logic [8:0]  mask_wide;
    logic [31:0] shifted;
    logic [7:0]  field;
    logic [7:0]  reduced;

    always_comb begin
        len       = (i_bits > 4'd8) ? 4'd8 : i_bits;
        mask_wide = (9'd1 << len) - 9'd1;
        shifted   = i_word >> i_shift;
        field     = shifted[7:0] & mask_wide[7:0];
        reduced   = f_mod(field);
        o_addr    = reduced[AW-1:0];
    end

endmodule
`default_nettype wire

// File: design/fbpu_palette.sv
`default_nettype none
module fbpu_palette #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: design/fbpu_format.sv
`default_nettype none
module fbpu_format
    import fbpu_pkg::*;
(
    input  wire t_cfg        i_cfg,
    input  wire logic [31:0] i_word,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    output t_out_item        o_item
);

    logic [15:0] gray_sum;
    logic [7:0]  mono;

    always_comb begin
        gray_sum = 16'(GRAY_W_RED) * 16'(i_red) + 16'(GRAY_W_GREEN) * 16'(i_green)
                 + 16'(GRAY_W_BLUE) * 16'(i_blue);
        for (int i = 0; i < 8; i++) begin
            mono[7-i] = i_word[i];
        end
        o_item.first_byte  = i_red;
        o_item.second_byte = i_green;
        o_item.third_byte  = i_blue;
        o_item.byte_count  = COUNT_THREE;
        case (i_cfg.output_mode)
            MODE_GRAY: begin
                o_item.first_byte  = gray_sum[15:8];
                o_item.second_byte = 8'd0;
                o_item.third_byte  = 8'd0;
                o_item.byte_count  = COUNT_ONE;
            end
            MODE_RAW: begin
                o_item.first_byte  = i_word[7:0];
                o_item.second_byte = i_word[15:8];
                o_item.third_byte  = i_word[23:16];
            end
            MODE_MONO, MODE_MONO_INV: begin
                o_item.first_byte  = (i_cfg.output_mode == MODE_MONO_INV) ? ~mono : mono;
                o_item.second_byte = 8'd0;
                o_item.third_byte  = 8'd0;
                o_item.byte_count  = COUNT_ONE;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire
